// ===== sv/vtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared widths, types and constants for the vertex transform pipeline.
// ----------------------------------------------------------------------------
package vtp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    // three shifted products plus one coefficient never overflow this
    localparam int ACC_W     = PROD_W - FRAC_BITS + 2;
    localparam int DIVD_W    = ACC_W + FRAC_BITS;
    localparam int QUO_W     = COORD_W + 1;
    localparam int HI_W      = DIVD_W - QUO_W;
    localparam int LANE_ST   = QUO_W + 3;
    localparam int XF_ST     = 2;
    localparam int NST       = XF_ST + LANE_ST;

    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 64;
    localparam int CFG_IDX_W = 8;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic [ACC_W-1:0]          mag_t;
    typedef logic [QUO_W-1:0]          quo_t;
    typedef coord_t [3:0]              coef_row_t;
    typedef coef_row_t [3:0]           coef_mat_t;
    typedef acc_t [3:0]                acc_vec_t;
    typedef logic [REG_W-1:0]          cfg_word_t;

    localparam acc_t      ONE_ACC   = acc_t'(ACC_W'(1) << FRAC_BITS);
    localparam cfg_word_t ONE_LO    = REG_W'(1) << FRAC_BITS;
    localparam cfg_word_t ONE_HI    = REG_W'(1) << (FRAC_BITS + COORD_W);
    localparam cfg_word_t CFG_ZERO  = '0;

    localparam quo_t LIMIT_POS = quo_t'((QUO_W'(1) << (COORD_W - 1)) - QUO_W'(1));
    localparam quo_t LIMIT_NEG = quo_t'(QUO_W'(1) << (COORD_W - 1));

endpackage

// ===== sv/vertex_transform_perspective_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_perspective_core
// 4x4 homogeneous vertex transform with perspective divide, fixed point.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  vertex  | s_valid s_ready s_pos_x s_pos_y s_pos_z | in
//  result  | m_valid m_ready m_out_x/y/z m_clipped   | out
//  matrix  | cfg_valid cfg_ready cfg_index cfg_data  | in
//
//  One item per cycle unless the output stalls; 2 matrix stages, 2 divider
//  set-up stages, 33 quotient-bit stages, 1 saturation/output stage.
//  Each stage holds its item while the next is full and stalled, so bubbles
//  close up; the input is taken while a result waits if a stage is empty.
//  Reset clears the valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_core import vtp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  coord_t               s_pos_x,
    input  coord_t               s_pos_y,
    input  coord_t               s_pos_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output coord_t               m_out_x,
    output coord_t               m_out_y,
    output coord_t               m_out_z,
    output logic                 m_clipped,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  cfg_word_t            cfg_data
);

    localparam cfg_word_t [NUM_REGS-1:0] CFG_RESET = {
        ONE_HI, CFG_ZERO, ONE_LO, CFG_ZERO, CFG_ZERO, ONE_HI, CFG_ZERO, ONE_LO
    };

    cfg_word_t [NUM_REGS-1:0] cfg_reg;
    coef_mat_t                coef;
    logic [NST-1:0]           v_reg, v_next;
    logic [NST:0]             en;
    acc_vec_t                 acc;
    logic [2:0]               sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            cfg_reg[cfg_index[$clog2(NUM_REGS)-1:0]] <= cfg_data;
        end
    end

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                coef[r][c] = cfg_reg[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
            end
        end
    end

    // a stage loads when it is empty or its successor moves on
    always_comb begin
        en[NST] = m_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = ({v_reg[NST-2:0], s_valid} & en[NST-1:0]) | (v_reg & ~en[NST-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[NST-1];

    vtp_xform u_xform (
        .aclk    (aclk),
        .en_i    (en[XF_ST-1:0]),
        .pos_x_i (s_pos_x),
        .pos_y_i (s_pos_y),
        .pos_z_i (s_pos_z),
        .coef_i  (coef),
        .acc_o   (acc)
    );

    vtp_div_lane u_div_x (
        .aclk  (aclk),
        .en_i  (en[NST-1:XF_ST]),
        .n_i   (acc[0]),
        .w_i   (acc[3]),
        .q_o   (m_out_x),
        .sat_o (sat[0])
    );

    vtp_div_lane u_div_y (
        .aclk  (aclk),
        .en_i  (en[NST-1:XF_ST]),
        .n_i   (acc[1]),
        .w_i   (acc[3]),
        .q_o   (m_out_y),
        .sat_o (sat[1])
    );

    vtp_div_lane u_div_z (
        .aclk  (aclk),
        .en_i  (en[NST-1:XF_ST]),
        .n_i   (acc[2]),
        .w_i   (acc[3]),
        .q_o   (m_out_z),
        .sat_o (sat[2])
    );

    assign m_clipped = |sat;

endmodule

// ===== sv/vtp_xform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_xform
// Row vector times 4x4 matrix: registered products, then registered sums.
// ----------------------------------------------------------------------------
module vtp_xform import vtp_pkg::*; (
    input  logic      aclk,
    input  logic [1:0] en_i,
    input  coord_t    pos_x_i,
    input  coord_t    pos_y_i,
    input  coord_t    pos_z_i,
    input  coef_mat_t coef_i,
    output acc_vec_t  acc_o
);

    logic signed [PROD_W-1:0] prod_reg  [3][4];
    logic signed [PROD_W-1:0] prod_next [3][4];
    acc_vec_t acc_reg, acc_next;
    coord_t   pos [3];

    assign pos[0] = pos_x_i;
    assign pos[1] = pos_y_i;
    assign pos[2] = pos_z_i;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 4; c++) begin
                prod_next[k][c] = PROD_W'($signed(pos[k])) * PROD_W'($signed(coef_i[k][c]));
            end
        end
    end

    // floor shift of each product, then the translation row
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            acc_next[c] = ACC_W'($signed(coef_i[3][c]))
                        + ACC_W'(prod_reg[0][c] >>> FRAC_BITS)
                        + ACC_W'(prod_reg[1][c] >>> FRAC_BITS)
                        + ACC_W'(prod_reg[2][c] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i[0]) begin
            prod_reg <= prod_next;
        end
        if (en_i[1]) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_o = acc_reg;

endmodule

// ===== sv/vtp_div_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_div_lane
// Pipelined restoring divide of one coordinate by w, one quotient bit per
// stage, with saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
module vtp_div_lane import vtp_pkg::*; (
    input  logic               aclk,
    input  logic [LANE_ST-1:0] en_i,
    input  acc_t               n_i,
    input  acc_t               w_i,
    output coord_t             q_o,
    output logic               sat_o
);

    // magnitude stage
    mag_t an_reg, an_next, aw0_reg, aw0_next;
    logic neg0_reg, neg0_next;

    // division stages: index 1 is the set-up, QUO_W+1 the last step
    mag_t             r_reg   [1:QUO_W+1];
    logic [QUO_W-1:0] lo_reg  [1:QUO_W+1];
    quo_t             q_reg   [1:QUO_W+1];
    mag_t             aw_reg  [1:QUO_W+1];
    logic             neg_reg [1:QUO_W+1];
    logic             big_reg [1:QUO_W+1];

    coord_t q_out_reg, q_out_next;
    logic   sat_reg, sat_next;

    always_comb begin
        acc_t wf;
        wf        = (w_i == '0) ? ONE_ACC : w_i;
        an_next   = n_i[ACC_W-1] ? mag_t'(-n_i) : mag_t'(n_i);
        aw0_next  = wf[ACC_W-1]  ? mag_t'(-wf)  : mag_t'(wf);
        neg0_next = n_i[ACC_W-1] ^ wf[ACC_W-1];
    end

    always_ff @(posedge aclk) begin
        if (en_i[0]) begin
            an_reg   <= an_next;
            aw0_reg  <= aw0_next;
            neg0_reg <= neg0_next;
        end
    end

    // set-up: top part of the scaled dividend; if it already reaches w the
    // quotient cannot fit
    always_ff @(posedge aclk) begin
        logic [DIVD_W-1:0] d;
        d = {an_reg, FRAC_BITS'(0)};
        if (en_i[1]) begin
            r_reg[1]   <= ACC_W'(d[DIVD_W-1 -: HI_W]);
            lo_reg[1]  <= d[QUO_W-1:0];
            q_reg[1]   <= '0;
            aw_reg[1]  <= aw0_reg;
            neg_reg[1] <= neg0_reg;
            big_reg[1] <= ACC_W'(d[DIVD_W-1 -: HI_W]) >= aw0_reg;
        end
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_step
        logic [ACC_W:0] t, diff;
        logic           ge;

        always_comb begin
            t    = {r_reg[s], lo_reg[s][QUO_W-1]};
            diff = t - {1'b0, aw_reg[s]};
            ge   = t >= {1'b0, aw_reg[s]};
        end

        always_ff @(posedge aclk) begin
            if (en_i[s+1]) begin
                r_reg[s+1]   <= ge ? diff[ACC_W-1:0] : t[ACC_W-1:0];
                lo_reg[s+1]  <= {lo_reg[s][QUO_W-2:0], 1'b0};
                q_reg[s+1]   <= {q_reg[s][QUO_W-2:0], ge};
                aw_reg[s+1]  <= aw_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                big_reg[s+1] <= big_reg[s];
            end
        end
    end

    always_comb begin
        quo_t lim, qs;
        lim      = neg_reg[QUO_W+1] ? LIMIT_NEG : LIMIT_POS;
        sat_next = big_reg[QUO_W+1] || (q_reg[QUO_W+1] > lim);
        qs       = sat_next ? lim : q_reg[QUO_W+1];
        qs       = neg_reg[QUO_W+1] ? quo_t'(-qs) : qs;
        q_out_next = coord_t'(qs[COORD_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (en_i[QUO_W+2]) begin
            q_out_reg <= q_out_next;
            sat_reg   <= sat_next;
        end
    end

    assign q_o   = q_out_reg;
    assign sat_o = sat_reg;

endmodule
